/* design/assert_macros.svh */
// Assertion macros shared by the cube grid tetrahedraliser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while in reset.
`define CGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold at every edge, reset included.
`define CGT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/cgt_pkg.sv */
// Package with the shared types, constants and split table of the tetrahedraliser.
`timescale 1ns / 1ps

package cgt_pkg;

  localparam int CountW = 9;   // configured cell count per axis
  localparam int CoordW = 8;   // cell coordinate
  localparam int RowW   = 27;  // tetrahedron row
  localparam int VtxW   = 25;  // vertex index
  localparam int NumSlots = 5;
  localparam int SlotW  = 3;
  localparam int MAX_CELLS_PER_AXIS = 256;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CELLS_X = 2'd0,
    REG_CELLS_Y = 2'd1,
    REG_CELLS_Z = 2'd2
  } cgt_reg_e;

  // One classified cell as it travels from the front end to the back end.
  typedef struct packed {
    logic [3:0][VtxW-1:0] corner;    // lower four cube corners
    logic [RowW-1:0]      row_base;  // linear cell index times five
    logic                 parity;    // parity of x+y+z
    logic                 oor;       // cell lies outside the grid
  } cgt_cell_t;

  // Corner numbers per tetrahedron, already reversed: [parity][slot][corner].
  // Bit 2 of a corner number selects the upper (+z) face.
  localparam logic [2:0] TET_TABLE [2][NumSlots][4] = '{
    '{ '{3'd0, 3'd4, 3'd1, 3'd3}, '{3'd2, 3'd3, 3'd1, 3'd6}, '{3'd5, 3'd6, 3'd1, 3'd4},
       '{3'd7, 3'd4, 3'd3, 3'd6}, '{3'd4, 3'd6, 3'd1, 3'd3} },
    '{ '{3'd2, 3'd5, 3'd0, 3'd1}, '{3'd6, 3'd7, 3'd2, 3'd5}, '{3'd4, 3'd5, 3'd0, 3'd7},
       '{3'd3, 3'd7, 3'd0, 3'd2}, '{3'd2, 3'd7, 3'd0, 3'd5} }
  };

endpackage

/* design/cgt_front.sv */
// Front end: accepts cell requests, checks the range and computes corner and row bases.
`timescale 1ns / 1ps

module cgt_front import cgt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic [CoordW-1:0] cell_z_i,
  input  logic [CountW-1:0] cells_x_i,
  input  logic [CountW-1:0] cells_y_i,
  input  logic [CountW-1:0] cells_z_i,
  output logic              push_o,
  output cgt_cell_t         entry_o,
  input  logic              q_ready_i
);

  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] r);
    logic [CountW-1:0] res;
    res = r;
    if (int'(r) > MAX_CELLS_PER_AXIS) res = CountW'(MAX_CELLS_PER_AXIS);
    return res;
  endfunction

  logic [CountW-1:0] w, h, d;
  logic [9:0]  sy_d;
  logic [19:0] sx_full;
  logic [17:0] hd_full;
  logic [15:0] y_sy_d;
  logic [16:0] y_d_d;

  logic en1, en2, en3, en4;

  // Stage 1
  logic              s1_valid_q;
  logic [CoordW-1:0] s1_x_q, s1_z_q;
  logic [15:0]       s1_y_sy_q;
  logic [16:0]       s1_y_d_q;
  logic [16:0]       s1_sx_q, s1_hd_q;
  logic [9:0]        s1_sy_q;
  logic              s1_par_q, s1_oor_q;

  // Stage 2
  logic              s2_valid_q;
  logic [VtxW-1:0]   s2_x_sx_q, s2_x_hd_q;
  logic [CoordW-1:0] s2_z_q;
  logic [15:0]       s2_y_sy_q;
  logic [16:0]       s2_y_d_q;
  logic [16:0]       s2_sx_q;
  logic [9:0]        s2_sy_q;
  logic              s2_par_q, s2_oor_q;

  // Stage 3
  logic              s3_valid_q;
  logic [VtxW-1:0]   s3_base_q, s3_cell_q;
  logic [16:0]       s3_sx_q;
  logic [9:0]        s3_sy_q;
  logic              s3_par_q, s3_oor_q;

  // Stage 4
  logic              s4_valid_q;
  cgt_cell_t         s4_entry_q, s4_entry_d;

  assign en4 = !s4_valid_q || q_ready_i;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_ready_o = en1;

  assign w = clamp_count(cells_x_i);
  assign h = clamp_count(cells_y_i);
  assign d = clamp_count(cells_z_i);

  assign sy_d    = {1'b0, d} + 10'd1;
  assign sx_full = ({10'd0, {1'b0, h} + 10'd1}) * {10'd0, sy_d};
  assign hd_full = {9'd0, h} * {9'd0, d};
  assign y_sy_d  = {8'd0, cell_y_i} * {6'd0, sy_d};
  assign y_d_d   = {9'd0, cell_y_i} * {8'd0, d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
      if (en4) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_x_q    <= cell_x_i;
      s1_z_q    <= cell_z_i;
      s1_y_sy_q <= y_sy_d;
      s1_y_d_q  <= y_d_d;
      s1_sx_q   <= sx_full[16:0];
      s1_hd_q   <= hd_full[16:0];
      s1_sy_q   <= sy_d;
      s1_par_q  <= cell_x_i[0] ^ cell_y_i[0] ^ cell_z_i[0];
      s1_oor_q  <= ({1'b0, cell_x_i} >= w) || ({1'b0, cell_y_i} >= h) ||
                   ({1'b0, cell_z_i} >= d);
    end
    if (en2) begin
      s2_x_sx_q <= {17'd0, s1_x_q} * {8'd0, s1_sx_q};
      s2_x_hd_q <= {17'd0, s1_x_q} * {8'd0, s1_hd_q};
      s2_z_q    <= s1_z_q;
      s2_y_sy_q <= s1_y_sy_q;
      s2_y_d_q  <= s1_y_d_q;
      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
      s2_par_q  <= s1_par_q;
      s2_oor_q  <= s1_oor_q;
    end
    if (en3) begin
      s3_base_q <= s2_x_sx_q + {9'd0, s2_y_sy_q} + {17'd0, s2_z_q};
      s3_cell_q <= s2_x_hd_q + {8'd0, s2_y_d_q} + {17'd0, s2_z_q};
      s3_sx_q   <= s2_sx_q;
      s3_sy_q   <= s2_sy_q;
      s3_par_q  <= s2_par_q;
      s3_oor_q  <= s2_oor_q;
    end
    if (en4) s4_entry_q <= s4_entry_d;
  end

  // Lower face corners: origin, +x, +x+y, +y. Out-of-range cells carry zeros.
  always_comb begin
    s4_entry_d = '0;
    s4_entry_d.parity = s3_par_q;
    s4_entry_d.oor    = s3_oor_q;
    if (!s3_oor_q) begin
      s4_entry_d.corner[0] = s3_base_q;
      s4_entry_d.corner[1] = s3_base_q + {8'd0, s3_sx_q};
      s4_entry_d.corner[2] = s3_base_q + {8'd0, s3_sx_q} + {15'd0, s3_sy_q};
      s4_entry_d.corner[3] = s3_base_q + {15'd0, s3_sy_q};
      s4_entry_d.row_base  = {s3_cell_q, 2'b00} + {2'b00, s3_cell_q};
    end
  end

  assign push_o  = s4_valid_q;
  assign entry_o = s4_entry_q;

endmodule

/* design/cgt_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module cgt_queue import cgt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      ready_o,
  input  cgt_cell_t entry_i,
  output logic      head_valid_o,
  output cgt_cell_t head_o,
  input  logic      pop_i
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  cgt_cell_t         store_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o      = (count_q != (PtrW + 1)'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = store_q[rd_ptr_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_ptr_q] <= entry_i;
  end

endmodule

/* design/cgt_back.sv */
// Back end: expands one queued cell into five tetrahedra, or one out-of-range result, through an output register.
`timescale 1ns / 1ps

module cgt_back import cgt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  cgt_cell_t       head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [RowW-1:0] tet_row_o,
  output logic [VtxW-1:0] corner_a_o,
  output logic [VtxW-1:0] corner_b_o,
  output logic [VtxW-1:0] corner_c_o,
  output logic [VtxW-1:0] corner_d_o,
  output logic            last_of_cell_o,
  output logic            out_of_range_o
);

  logic [SlotW-1:0]     slot_q, slot_d;
  logic                 out_valid_q;
  logic [RowW-1:0]      row_q, row_d;
  logic [3:0][VtxW-1:0] vtx_q, vtx_d;
  logic                 last_q, last_d;
  logic                 oor_q;
  logic                 load;
  logic [2:0]           num;

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_d = (slot_q == SlotW'(NumSlots - 1));
  assign pop_o = load && (head_i.oor || last_d);

  always_comb begin
    slot_d = slot_q;
    if (load) slot_d = pop_o ? '0 : slot_q + 1'b1;
  end

  // Upper corners are the lower ones plus one along z.
  always_comb begin
    num   = '0;
    vtx_d = '0;
    row_d = '0;
    if (!head_i.oor) begin
      row_d = head_i.row_base + {{(RowW - SlotW){1'b0}}, slot_q};
      for (int k = 0; k < 4; k++) begin
        num = TET_TABLE[head_i.parity][slot_q][k];
        vtx_d[k] = head_i.corner[num[1:0]] + {{(VtxW - 1){1'b0}}, num[2]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (!out_valid_q || out_ready_i) out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q  <= row_d;
      vtx_q  <= vtx_d;
      last_q <= last_d && !head_i.oor;
      oor_q  <= head_i.oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tet_row_o      = row_q;
  assign corner_a_o     = vtx_q[0];
  assign corner_b_o     = vtx_q[1];
  assign corner_c_o     = vtx_q[2];
  assign corner_d_o     = vtx_q[3];
  assign last_of_cell_o = last_q;
  assign out_of_range_o = oor_q;

endmodule

/* design/cube_grid_tetrahedralizer.sv */
// Top level of the cube grid tetrahedraliser: configuration registers and block wiring.
// Usage: program cells_x, cells_y and cells_z through the configuration channel
// (index 0, 1 and 2) while the block is idle, then send cell coordinates on the
// input channel. Each request inside the grid yields five tetrahedra, one result
// per cycle while the receiver is ready, each with its row number and four vertex
// indices; the fifth carries last_of_cell. A cell outside the grid yields a single
// result with out_of_range set and all other fields zero. Counts above
// MAX_CELLS_PER_AXIS are clamped. An accepted request passes the four front-end
// stages, the queue, then the output register before its first result appears.
// Throughput: the output register emits one result per cycle while the receiver is
// ready, five per cell or one when out of range. The front end keeps accepting
// requests until its pipeline and the two-entry queue are full.
// Reset returns all counts to one and empties the pipeline, queue and output.
// When the receiver stalls, the output register holds its result, the queue
// fills and the input ready drops only once the front end has no room left.
// Configuration writes are always accepted; an unknown index is ignored.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cube_grid_tetrahedralizer import cgt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CountW-1:0] cfg_data_i,
  // Cell request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic [CoordW-1:0] cell_z_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RowW-1:0]   tet_row_o,
  output logic [VtxW-1:0]   corner_a_o,
  output logic [VtxW-1:0]   corner_b_o,
  output logic [VtxW-1:0]   corner_c_o,
  output logic [VtxW-1:0]   corner_d_o,
  output logic              last_of_cell_o,
  output logic              out_of_range_o
);

  logic [CountW-1:0] cells_x_q, cells_y_q, cells_z_q;
  logic              push, q_ready, head_valid, pop;
  cgt_cell_t         entry, head;

  // The configuration registers never stall a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CountW'(1);
      cells_y_q <= CountW'(1);
      cells_z_q <= CountW'(1);
    end else if (cfg_valid_i) begin
      case (cgt_reg_e'(cfg_index_i))
        REG_CELLS_X: cells_x_q <= cfg_data_i;
        REG_CELLS_Y: cells_y_q <= cfg_data_i;
        REG_CELLS_Z: cells_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cgt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cell_x_i  (cell_x_i),
    .cell_y_i  (cell_y_i),
    .cell_z_i  (cell_z_i),
    .cells_x_i (cells_x_q),
    .cells_y_i (cells_y_q),
    .cells_z_i (cells_z_q),
    .push_o    (push),
    .entry_o   (entry),
    .q_ready_i (q_ready)
  );

  cgt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (q_ready),
    .entry_i     (entry),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  cgt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tet_row_o     (tet_row_o),
    .corner_a_o    (corner_a_o),
    .corner_b_o    (corner_b_o),
    .corner_c_o    (corner_c_o),
    .corner_d_o    (corner_d_o),
    .last_of_cell_o(last_of_cell_o),
    .out_of_range_o(out_of_range_o)
  );

  // An out-of-range result is a lone, all-zero result.
  property p_oor_zero;
    (out_valid_o && out_of_range_o) |->
      (tet_row_o == '0 && !last_of_cell_o && corner_a_o == '0);
  endproperty

  // Within a cell the next tetrahedron follows at once with the next row.
  property p_row_step;
    (out_valid_o && out_ready_i && !last_of_cell_o && !out_of_range_o) |=>
      (out_valid_o && tet_row_o == $past(tet_row_o) + 27'd1);
  endproperty

  // While the queue is full, the front end holds its pending entry.
  property p_no_overflow;
    push && !q_ready |=> $stable(entry);
  endproperty

  `CGT_ASSERT(a_oor_zero, p_oor_zero, "out-of-range result carries data")
  `CGT_ASSERT(a_row_step, p_row_step, "tetrahedron rows of a cell are not consecutive")
  `CGT_ASSERT(a_no_overflow, p_no_overflow, "queue push while full lost its entry")

endmodule
